// ===== hw/rtl/tcpa_pkg.sv =====
// Shared types and constants of the two-class priority admission block.
`default_nettype none

package tcpa_pkg;

	// Width of the capacity register and of the occupancy count, and reset value of the capacity register.
	localparam int unsigned CAP_BITS = 8;
	localparam logic [CAP_BITS-1:0] CAP_RESET = 8'd2;

	// Request command codes.
	localparam logic CMD_ARRIVE = 1'b0;
	localparam logic CMD_DEPART = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		STATUS_NONE  = 2'd0,
		STATUS_ADMIT = 2'd1,
		STATUS_DROP  = 2'd2,
		STATUS_EMPTY = 2'd3
	} status_t;

	// Controller states: idle, or waiting for a queue head read.
	typedef enum logic {
		CTL_IDLE,
		CTL_READ
	} ctl_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tcpa_req_if.sv =====
// Request and response channel interfaces of the two-class priority admission block.
`default_nettype none

interface tcpa_req_if #(
	parameter int unsigned ID_BITS = 16
);
	logic               valid;
	logic               ready;
	logic               cmd;
	logic               is_priority;
	logic [ID_BITS-1:0] client_id;

	modport source (output valid, cmd, is_priority, client_id, input ready);
	modport sink   (input valid, cmd, is_priority, client_id, output ready);
endinterface

interface tcpa_rsp_if #(
	parameter int unsigned ID_BITS  = 16,
	parameter int unsigned CAP_BITS = 8
);
	logic                valid;
	logic                ready;
	logic [1:0]          status;
	logic [ID_BITS-1:0]  admitted_id;
	logic                admitted_priority;
	logic [CAP_BITS-1:0] occupancy_now;

	modport source (output valid, status, admitted_id, admitted_priority, occupancy_now,
		input ready);
	modport sink   (input valid, status, admitted_id, admitted_priority, occupancy_now,
		output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tcpa_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module tcpa_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/two_class_priority_admission.sv =====
// Top level of the two-class strict-priority admission controller.
//
// Channel     Dir  Handshake      Payload
// req         in   valid/ready    cmd, is_priority, client_id
// rsp         out  valid/ready    status, admitted_id, admitted_priority, occupancy_now
// capacity    in   capacity_we    capacity_wdata (8 bits, no read-back)
//
// For an arrival, a dropped arrival and any departure that admits nobody, the result
// is registered at the edge that accepts the request. A departure that admits a
// waiting client passes through the read state first, because the queue head comes
// out of a synchronous RAM with registered read data. Reset clears occupancy, both queue
// pointers and the controller; the queue RAMs hold no reset. The next request is
// taken in the cycle the result is taken, so a stalled response stalls requests.
`default_nettype none

module two_class_priority_admission #(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned ID_BITS     = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	tcpa_req_if.sink                         req,
	tcpa_rsp_if.source                       rsp,
	input  wire logic                        capacity_we,
	input  wire logic [tcpa_pkg::CAP_BITS-1:0] capacity_wdata
);

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned OCC_W = tcpa_pkg::CAP_BITS;

	// Architectural state: capacity, occupancy and the head/count pair of each queue.
	logic [OCC_W-1:0] cap_q;
	logic [OCC_W-1:0] occ_q;
	logic [PTR_W-1:0] p_head_q;
	logic [CNT_W-1:0] p_cnt_q;
	logic [PTR_W-1:0] n_head_q;
	logic [CNT_W-1:0] n_cnt_q;

	tcpa_pkg::ctl_state_t state_q, state_d;
	logic                 pend_pri_q;

	// Response register.
	logic                  out_valid_q;
	tcpa_pkg::status_t     out_status_q;
	logic [ID_BITS-1:0]    out_id_q;
	logic                  out_pri_q;
	logic [OCC_W-1:0]      out_occ_q;

	// Queue RAM ports.
	logic               p_we, n_we, p_re, n_re;
	logic [PTR_W-1:0]   wr_addr;
	logic [ID_BITS-1:0] p_rdata, n_rdata;

	// Decode of the request against the current state.
	logic               accept;
	logic               is_dep;
	logic               room;
	logic               p_empty, n_empty;
	logic               go;
	logic [CNT_W-1:0]   push_cnt;
	logic [PTR_W-1:0]   push_head;
	logic               push_full;
	logic [PTR_W:0]     tail_sum;
	logic               occ_zero;
	logic [OCC_W-1:0]   occ_dec;
	logic               pop;
	logic               pop_pri;
	logic [PTR_W-1:0]   pop_head;
	logic [PTR_W-1:0]   pop_head_next;

	// A request is taken only while no head read is pending and the response
	// register is free or is being emptied at this edge. That interlock also keeps
	// a push from ever meeting a pop of the same queue in flight.
	assign req.ready = (state_q == tcpa_pkg::CTL_IDLE) && (!out_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign is_dep    = (req.cmd == tcpa_pkg::CMD_DEPART);

	always_comb begin
		room    = occ_q < cap_q;
		p_empty = (p_cnt_q == '0);
		n_empty = (n_cnt_q == '0);

		// A high-priority arrival passes only an empty high-priority queue; a normal
		// arrival must also find the normal queue empty.
		go = room && p_empty && (req.is_priority || n_empty);

		push_cnt  = req.is_priority ? p_cnt_q : n_cnt_q;
		push_head = req.is_priority ? p_head_q : n_head_q;
		push_full = (push_cnt == CNT_W'(QUEUE_DEPTH));

		// Tail slot is head plus count, wrapped once around the queue depth.
		tail_sum = {1'b0, push_head} + (PTR_W + 1)'(push_cnt);
		if (tail_sum >= (PTR_W + 1)'(QUEUE_DEPTH)) begin
			wr_addr = PTR_W'(tail_sum - (PTR_W + 1)'(QUEUE_DEPTH));
		end else begin
			wr_addr = tail_sum[PTR_W-1:0];
		end

		// A departure frees one place and hands it to a waiting client only if the
		// room is then below capacity; the high-priority queue goes first.
		occ_zero = (occ_q == '0);
		occ_dec  = occ_q - OCC_W'(1);
		pop      = !occ_zero && (occ_dec < cap_q) && (!p_empty || !n_empty);
		pop_pri  = !p_empty;
		pop_head = pop_pri ? p_head_q : n_head_q;
		if (pop_head == PTR_W'(QUEUE_DEPTH - 1)) begin
			pop_head_next = '0;
		end else begin
			pop_head_next = pop_head + PTR_W'(1);
		end

		p_we = accept && !is_dep && !go && !push_full && req.is_priority;
		n_we = accept && !is_dep && !go && !push_full && !req.is_priority;
		p_re = accept && is_dep && pop && pop_pri;
		n_re = accept && is_dep && pop && !pop_pri;
	end

	tcpa_ram #(
		.WIDTH (ID_BITS),
		.DEPTH (QUEUE_DEPTH)
	) u_p_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (wr_addr),
		.wdata (req.client_id),
		.re    (p_re),
		.raddr (p_head_q),
		.rdata (p_rdata)
	);

	tcpa_ram #(
		.WIDTH (ID_BITS),
		.DEPTH (QUEUE_DEPTH)
	) u_n_ram (
		.clk   (clk),
		.we    (n_we),
		.waddr (wr_addr),
		.wdata (req.client_id),
		.re    (n_re),
		.raddr (n_head_q),
		.rdata (n_rdata)
	);

	// Controller: a departure that pops waits in the read state for the
	// RAM data, then the response register is loaded from it.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tcpa_pkg::CTL_IDLE: begin
				if (accept && is_dep && pop) begin
					state_d = tcpa_pkg::CTL_READ;
				end
			end
			tcpa_pkg::CTL_READ: begin
				state_d = tcpa_pkg::CTL_IDLE;
			end
			default: begin
				state_d = tcpa_pkg::CTL_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcpa_pkg::CTL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Capacity register. The user must write it only while the block is idle; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= tcpa_pkg::CAP_RESET;
		end else if (capacity_we) begin
			cap_q <= capacity_wdata;
		end
	end

	// Occupancy and queue pointers are updated at the accepting edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q    <= '0;
			p_head_q <= '0;
			p_cnt_q  <= '0;
			n_head_q <= '0;
			n_cnt_q  <= '0;
		end else if (accept) begin
			if (!is_dep) begin
				if (go) begin
					occ_q <= occ_q + OCC_W'(1);
				end else if (!push_full) begin
					if (req.is_priority) begin
						p_cnt_q <= p_cnt_q + CNT_W'(1);
					end else begin
						n_cnt_q <= n_cnt_q + CNT_W'(1);
					end
				end
			end else if (!occ_zero) begin
				if (pop) begin
					// One leaves and one enters: occupancy is unchanged.
					if (pop_pri) begin
						p_head_q <= pop_head_next;
						p_cnt_q  <= p_cnt_q - CNT_W'(1);
					end else begin
						n_head_q <= pop_head_next;
						n_cnt_q  <= n_cnt_q - CNT_W'(1);
					end
				end else begin
					occ_q <= occ_dec;
				end
			end
		end
	end

	// Response valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_pri_q  <= 1'b0;
		end else begin
			if (state_q == tcpa_pkg::CTL_READ) begin
				out_valid_q <= 1'b1;
			end else if (accept) begin
				out_valid_q <= !(is_dep && pop);
				pend_pri_q  <= pop_pri;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Response payload. The occupancy after a popping departure is its value
	// before the request, so it is stored already at the accepting edge.
	always_ff @(posedge clk) begin
		if (state_q == tcpa_pkg::CTL_READ) begin
			out_status_q <= tcpa_pkg::STATUS_ADMIT;
			out_id_q     <= pend_pri_q ? p_rdata : n_rdata;
			out_pri_q    <= pend_pri_q;
		end else if (accept) begin
			out_status_q <= tcpa_pkg::STATUS_NONE;
			out_id_q     <= '0;
			out_pri_q    <= 1'b0;
			out_occ_q    <= occ_q;
			if (!is_dep) begin
				if (go) begin
					out_status_q <= tcpa_pkg::STATUS_ADMIT;
					out_id_q     <= req.client_id;
					out_pri_q    <= req.is_priority;
					out_occ_q    <= occ_q + OCC_W'(1);
				end else if (push_full) begin
					out_status_q <= tcpa_pkg::STATUS_DROP;
				end
			end else if (occ_zero) begin
				out_status_q <= tcpa_pkg::STATUS_EMPTY;
			end else if (!pop) begin
				out_occ_q <= occ_dec;
			end
		end
	end

	assign rsp.valid             = out_valid_q;
	assign rsp.status            = out_status_q;
	assign rsp.admitted_id       = out_id_q;
	assign rsp.admitted_priority = out_pri_q;
	assign rsp.occupancy_now     = out_occ_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tcpa_checker.sv =====
// Port-level assertions of the two-class priority admission block and their binding.
`default_nettype none

module tcpa_checker #(
	parameter int unsigned ID_BITS = 16
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_ready,
	input wire logic [1:0]                    rsp_status,
	input wire logic [ID_BITS-1:0]            rsp_admitted_id,
	input wire logic                          rsp_admitted_priority,
	input wire logic [tcpa_pkg::CAP_BITS-1:0] rsp_occupancy_now
);

	// A response held under backpressure stays valid.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	// Someone was just admitted, so the room cannot be empty.
	a_admit_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == tcpa_pkg::STATUS_ADMIT) |-> (rsp_occupancy_now != '0))
		else $error("admission reported with zero occupancy");

	// Id and class are zero unless a client was admitted.
	a_no_admit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != tcpa_pkg::STATUS_ADMIT)
		|-> (rsp_admitted_id == '0) && !rsp_admitted_priority)
		else $error("admitted fields set without an admission");

	// A departure from an empty room leaves it empty.
	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == tcpa_pkg::STATUS_EMPTY) |-> (rsp_occupancy_now == '0))
		else $error("empty-room departure with nonzero occupancy");

endmodule

bind two_class_priority_admission tcpa_checker #(
	.ID_BITS (ID_BITS)
) u_tcpa_checker (
	.clk                   (clk),
	.arst_n                (arst_n),
	.rsp_valid             (rsp.valid),
	.rsp_ready             (rsp.ready),
	.rsp_status            (rsp.status),
	.rsp_admitted_id       (rsp.admitted_id),
	.rsp_admitted_priority (rsp.admitted_priority),
	.rsp_occupancy_now     (rsp.occupancy_now)
);

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the two-class priority admission controller.
`timescale 1ns / 100ps

module tb;
	import tcpa_pkg::*;

	localparam int unsigned QUEUE_DEPTH = 16;
	localparam int unsigned ID_BITS     = 16;
	localparam int unsigned QUIET_LIMIT = 4000;
	localparam int unsigned NUM_PHASES  = 14;
	localparam int unsigned PHASE_ITEMS = 75;
	localparam int unsigned HOLD_CYCLES = 300;

	// One response as the controller should produce it.
	typedef struct packed {
		status_t             status;
		logic [ID_BITS-1:0]  id;
		logic                pri;
		logic [CAP_BITS-1:0] occ;
	} outcome_t;

	// A directed row either sends one request or rewrites the capacity register.
	typedef enum logic {
		ROW_REQ,
		ROW_CAP
	} row_kind_t;

	typedef struct packed {
		row_kind_t           kind;
		logic                cmd;
		logic                pri;
		logic [ID_BITS-1:0]  id;
		logic [CAP_BITS-1:0] cap;
		logic                typed;
		outcome_t            exp;
	} dir_row_t;

	localparam outcome_t NO_TYPED = '{STATUS_NONE, 16'h0000, 1'b0, 8'd0};

	// Directed opening. Rows with typed set carry a result that is plain from the rules:
	// the empty room, first admissions, simple queueing. The other rows are left to the
	// predictor. The capacity drop to 1 while four clients are inside exercises the case
	// where departures admit nobody until the room falls below capacity.
	localparam int DIR_ROWS = 21;
	localparam dir_row_t DIRECTED[DIR_ROWS] = '{
		'{ROW_REQ, CMD_DEPART, 1'b0, 16'h0000, 8'd0,   1'b1, '{STATUS_EMPTY, 16'h0000, 1'b0, 8'd0}},
		'{ROW_REQ, CMD_ARRIVE, 1'b0, 16'hFFFF, 8'd0,   1'b1, '{STATUS_ADMIT, 16'hFFFF, 1'b0, 8'd1}},
		'{ROW_REQ, CMD_ARRIVE, 1'b1, 16'h0000, 8'd0,   1'b1, '{STATUS_ADMIT, 16'h0000, 1'b1, 8'd2}},
		'{ROW_REQ, CMD_ARRIVE, 1'b0, 16'h1234, 8'd0,   1'b1, '{STATUS_NONE,  16'h0000, 1'b0, 8'd2}},
		'{ROW_REQ, CMD_ARRIVE, 1'b1, 16'hABCD, 8'd0,   1'b1, '{STATUS_NONE,  16'h0000, 1'b0, 8'd2}},
		'{ROW_REQ, CMD_DEPART, 1'b0, 16'h0000, 8'd0,   1'b0, NO_TYPED},
		'{ROW_REQ, CMD_DEPART, 1'b0, 16'h0000, 8'd0,   1'b0, NO_TYPED},
		'{ROW_CAP, CMD_ARRIVE, 1'b0, 16'h0000, 8'd255, 1'b0, NO_TYPED},
		'{ROW_REQ, CMD_ARRIVE, 1'b1, 16'h5555, 8'd0,   1'b0, NO_TYPED},
		'{ROW_REQ, CMD_ARRIVE, 1'b0, 16'hAAAA, 8'd0,   1'b0, NO_TYPED},
		'{ROW_CAP, CMD_ARRIVE, 1'b0, 16'h0000, 8'd1,   1'b0, NO_TYPED},
		'{ROW_REQ, CMD_ARRIVE, 1'b0, 16'h0F0F, 8'd0,   1'b0, NO_TYPED},
		'{ROW_REQ, CMD_ARRIVE, 1'b1, 16'hF0F0, 8'd0,   1'b0, NO_TYPED},
		'{ROW_REQ, CMD_DEPART, 1'b0, 16'h0000, 8'd0,   1'b0, NO_TYPED},
		'{ROW_REQ, CMD_DEPART, 1'b1, 16'h7777, 8'd0,   1'b0, NO_TYPED},
		'{ROW_REQ, CMD_DEPART, 1'b0, 16'h0000, 8'd0,   1'b0, NO_TYPED},
		'{ROW_REQ, CMD_DEPART, 1'b0, 16'h0000, 8'd0,   1'b0, NO_TYPED},
		'{ROW_REQ, CMD_DEPART, 1'b0, 16'h0000, 8'd0,   1'b0, NO_TYPED},
		'{ROW_REQ, CMD_DEPART, 1'b0, 16'h0000, 8'd0,   1'b0, NO_TYPED},
		'{ROW_REQ, CMD_DEPART, 1'b1, 16'hFFFF, 8'd0,   1'b1, '{STATUS_EMPTY, 16'h0000, 1'b0, 8'd0}},
		'{ROW_CAP, CMD_ARRIVE, 1'b0, 16'h0000, 8'd2,   1'b0, NO_TYPED}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic capacity_we;
	logic [CAP_BITS-1:0] capacity_wdata;

	tcpa_req_if #(.ID_BITS(ID_BITS)) req_ch ();
	tcpa_rsp_if #(.ID_BITS(ID_BITS), .CAP_BITS(CAP_BITS)) rsp_ch ();

	two_class_priority_admission #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.ID_BITS    (ID_BITS)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req_ch),
		.rsp           (rsp_ch),
		.capacity_we   (capacity_we),
		.capacity_wdata(capacity_wdata)
	);

	// 20 ns period, high half first after the initial low.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predictor state: the room, the register and both waiting lines.
	logic [CAP_BITS-1:0] occ_model = '0;
	logic [CAP_BITS-1:0] cap_model = CAP_RESET;
	logic [ID_BITS-1:0]  pri_line[$];
	logic [ID_BITS-1:0]  norm_line[$];

	// Results still owed by the controller, oldest first.
	outcome_t pending_outcomes[$];

	// Handed from the driver to the monitor along with the request it goes with.
	logic     typed_pending = 1'b0;
	outcome_t typed_outcome = NO_TYPED;

	// Knobs shared by the driver and the response ready process.
	int unsigned gap_pct   = 0;
	int unsigned stall_pct = 0;
	int unsigned hold_request = 0;

	int unsigned errors = 0;
	int unsigned quiet_cycles = 0;
	int unsigned n_req = 0, n_admit = 0, n_queued = 0, n_drop = 0, n_empty = 0;
	int unsigned n_cap_writes = 0;
	logic [CAP_BITS-1:0] cap_lo = '1, cap_hi = '0;

	// Works out the response to one request and advances the predictor state. A new
	// high-priority client goes straight in when there is room and no other VIP waits;
	// a normal one also needs the normal line to be empty. A departure frees a place
	// and pulls the head of the VIP line first, but only if the room is then below
	// capacity, which matters when capacity was lowered under the current occupancy.
	function automatic outcome_t admit_decision(logic cmd, logic pri, logic [ID_BITS-1:0] id);
		outcome_t o;
		logic     room;
		logic     line_full;
		o = NO_TYPED;
		if (cmd == CMD_ARRIVE) begin
			room = occ_model < cap_model;
			line_full = pri ? (pri_line.size() >= QUEUE_DEPTH)
				: (norm_line.size() >= QUEUE_DEPTH);
			if (room && pri_line.size() == 0 && (pri || norm_line.size() == 0)) begin
				occ_model++;
				o.status = STATUS_ADMIT;
				o.id = id;
				o.pri = pri;
			end else if (line_full) begin
				o.status = STATUS_DROP;
			end else if (pri) begin
				pri_line.push_back(id);
			end else begin
				norm_line.push_back(id);
			end
		end else if (occ_model == 0) begin
			o.status = STATUS_EMPTY;
		end else begin
			occ_model--;
			if (occ_model < cap_model) begin
				if (pri_line.size() != 0) begin
					o.id = pri_line.pop_front();
					o.pri = 1'b1;
					occ_model++;
					o.status = STATUS_ADMIT;
				end else if (norm_line.size() != 0) begin
					o.id = norm_line.pop_front();
					o.pri = 1'b0;
					occ_model++;
					o.status = STATUS_ADMIT;
				end
			end
		end
		o.occ = occ_model;
		return o;
	endfunction

	task automatic note_mismatch(string field, logic [31:0] exp_v, logic [31:0] act_v);
		errors++;
		if (errors <= 10)
			$display("%0t: %s mismatch, expected %0h, got %0h", $realtime, field, exp_v, act_v);
	endtask

	// Field-by-field comparison of the response on the bus against one expectation.
	task automatic typed_outcome_check(outcome_t exp);
		if (rsp_ch.status !== exp.status)
			note_mismatch("status", 32'(exp.status), 32'(rsp_ch.status));
		if (rsp_ch.admitted_id !== exp.id)
			note_mismatch("admitted_id", 32'(exp.id), 32'(rsp_ch.admitted_id));
		if (rsp_ch.admitted_priority !== exp.pri)
			note_mismatch("admitted_priority", 32'(exp.pri), 32'(rsp_ch.admitted_priority));
		if (rsp_ch.occupancy_now !== exp.occ)
			note_mismatch("occupancy_now", 32'(exp.occ), 32'(rsp_ch.occupancy_now));
	endtask

	// Monitor. Everything here samples at the rising edge, where the controller's
	// registered outputs still hold their pre-edge values and the inputs were set up
	// at the previous falling edge. It also runs the watchdog: if nothing moves on
	// either channel or the register port for too long, the run is declared dead.
	always @(posedge clk) begin
		if (arst_n) begin
			if (capacity_we) begin
				cap_model = capacity_wdata;
				n_cap_writes++;
				if (capacity_wdata < cap_lo) cap_lo = capacity_wdata;
				if (capacity_wdata > cap_hi) cap_hi = capacity_wdata;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				case (rsp_ch.status)
					STATUS_ADMIT: n_admit++;
					STATUS_DROP:  n_drop++;
					STATUS_EMPTY: n_empty++;
					default:      n_queued++;
				endcase
				if (pending_outcomes.size() == 0) begin
					note_mismatch("unexpected response, status", 32'hFFFF_FFFF,
						32'(rsp_ch.status));
				end else begin
					typed_outcome_check(pending_outcomes.pop_front());
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				n_req++;
				if (typed_pending) begin
					void'(admit_decision(req_ch.cmd, req_ch.is_priority, req_ch.client_id));
					pending_outcomes.push_back(typed_outcome);
				end else begin
					pending_outcomes.push_back(
						admit_decision(req_ch.cmd, req_ch.is_priority, req_ch.client_id));
				end
			end
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || capacity_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no progress for %0d cycles, %0d results outstanding",
					$realtime, QUIET_LIMIT, pending_outcomes.size());
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Response ready. It changes only at falling edges. A hold request from the
	// stimulus turns into a stretch of stalled cycles counted down here, so the
	// controller's single result slot fills and it stops taking requests.
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
			end
		end
	end

	// Offers one request. Called at a falling edge and returns at the falling edge
	// after acceptance with valid still high, so that back-to-back requests never
	// see valid dropped and raised in the same time step.
	task automatic send_req(logic cmd, logic pri, logic [ID_BITS-1:0] id, logic typed,
		outcome_t exp);
		while ($urandom_range(99, 0) < gap_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		typed_pending = typed;
		typed_outcome = exp;
		req_ch.valid <= 1'b1;
		req_ch.cmd <= cmd;
		req_ch.is_priority <= pri;
		req_ch.client_id <= id;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Stops offering and waits until every result owed has been taken.
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending_outcomes.size() != 0) @(negedge clk);
	endtask

	// The register is only written while the controller is idle.
	task automatic write_capacity(logic [CAP_BITS-1:0] value);
		wait_drained();
		capacity_we <= 1'b1;
		capacity_wdata <= value;
		@(negedge clk);
		capacity_we <= 1'b0;
	endtask

	initial begin
		int unsigned arr_pct;
		logic        cmd;
		logic [CAP_BITS-1:0] cap_val;

		arst_n = 1'b0;
		capacity_we = 1'b0;
		capacity_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_ARRIVE;
		req_ch.is_priority = 1'b0;
		req_ch.client_id = '0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (DIRECTED[i].kind == ROW_CAP)
				write_capacity(DIRECTED[i].cap);
			else
				send_req(DIRECTED[i].cmd, DIRECTED[i].pri, DIRECTED[i].id,
					DIRECTED[i].typed, DIRECTED[i].exp);
		end

		// Random phases. Each one picks a capacity (small ones dominate so the lines
		// fill and overflow), an arrival mix, and one of the idling patterns. Phases
		// with a heavy arrival share push both lines to the drop case; lighter ones
		// drain them and reach departures from an empty room.
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p % 5)
				0: cap_val = 8'd1;
				1: cap_val = 8'($urandom_range(4, 2));
				2: cap_val = 8'd255;
				3: cap_val = 8'($urandom_range(255, 1));
				default: cap_val = 8'($urandom_range(8, 1));
			endcase
			write_capacity(cap_val);

			case (p % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 46; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 46; end
				default: begin gap_pct = 13; stall_pct = 13; end
			endcase
			arr_pct = (p % 2 == 0) ? $urandom_range(95, 75) : $urandom_range(60, 40);

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Long receiver hold-off with the sender still pushing requests.
				if (p == 0 && n == 20) hold_request = HOLD_CYCLES;
				// Sender pause that lets everything outstanding come back first.
				if (p == 5 && n == 40) wait_drained();
				cmd = ($urandom_range(99, 0) < arr_pct) ? CMD_ARRIVE : CMD_DEPART;
				send_req(cmd, 1'($urandom_range(1, 0)), ID_BITS'($urandom), 1'b0, NO_TYPED);
			end
		end

		wait_drained();
		gap_pct = 0;
		repeat (8) @(negedge clk);

		$display("Ran %0d requests across %0d capacity writes, capacity %0d to %0d.",
			n_req, n_cap_writes, cap_lo, cap_hi);
		$display("Results: %0d admitted, %0d queued, %0d dropped, %0d empty departures.",
			n_admit, n_queued, n_drop, n_empty);
		if (errors == 0 && pending_outcomes.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, pending_outcomes.size());
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/tcpa_pkg.sv
hw/rtl/tcpa_req_if.sv
hw/rtl/tcpa_ram.sv
hw/rtl/two_class_priority_admission.sv
hw/rtl/tcpa_checker.sv
dv/tb.sv
